[hw/rtl/inter_channel_pixel_predictor_unit_assert.svh]
// Assertion macros for the pixel predictor. Each expects i_clk and i_rst_n in scope.
`ifndef INTER_CHANNEL_PIXEL_PREDICTOR_UNIT_ASSERT_SVH
`define INTER_CHANNEL_PIXEL_PREDICTOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define ICPP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("icpp: same-cycle check failed");
`define ICPP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("icpp: next-cycle check failed");
`else
`define ICPP_ASSERT_SAME(lbl, ante, cons)
`define ICPP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hw/rtl/icpp_pkg.sv]
`default_nettype none
package icpp_pkg;

    localparam int MAX_WIDTH_DEF = 4096;
    localparam int SAMPLE_W      = 8;
    localparam int PIXEL_W       = 3 * SAMPLE_W;
    localparam int N_TERMS       = 11;
    localparam int WEIGHT_W      = 4;
    localparam int WEIGHTS_W     = N_TERMS * WEIGHT_W;
    localparam int RED_W_W       = 40;
    localparam int GREEN_W_W     = 36;
    localparam int BLUE_W_W      = 44;
    localparam int SHIFT_W       = 3;
    localparam int IMG_WIDTH_W   = 13;
    localparam int SUM_W         = 17;
    localparam int PROD_W        = WEIGHT_W + SAMPLE_W + 1;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 44;

    localparam logic [IMG_WIDTH_W-1:0] IMAGE_WIDTH_RESET = IMG_WIDTH_W'(4096);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RED_WEIGHTS   = 3'd0,
        CFG_GREEN_WEIGHTS = 3'd1,
        CFG_BLUE_WEIGHTS  = 3'd2,
        CFG_RED_SHIFT     = 3'd3,
        CFG_GREEN_SHIFT   = 3'd4,
        CFG_BLUE_SHIFT    = 3'd5,
        CFG_IMAGE_WIDTH   = 3'd6
    } t_cfg_idx;

    typedef logic [N_TERMS-1:0][SAMPLE_W-1:0] t_terms;

    typedef struct packed {
        logic [WEIGHTS_W-1:0] weights;
        logic [SHIFT_W-1:0]   shift;
    } t_chan_cfg;

endpackage
`default_nettype wire

[hw/rtl/icpp_row_mem.sv]
`default_nettype none
module icpp_row_mem
    import icpp_pkg::*;
#(
    parameter int DEPTH = MAX_WIDTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rd_en,
    input  wire logic [AW-1:0]      i_rd_addr,
    output logic      [PIXEL_W-1:0] o_rd_data,
    input  wire logic               i_wr_en,
    input  wire logic [AW-1:0]      i_wr_addr,
    input  wire logic [PIXEL_W-1:0] i_wr_data
);

    logic [PIXEL_W-1:0] r_mem [DEPTH];
    logic [PIXEL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

[hw/rtl/icpp_chan_pred.sv]
`default_nettype none
module icpp_chan_pred
    import icpp_pkg::*;
(
    input  wire t_terms             i_terms,
    input  wire t_chan_cfg          i_cfg,
    output logic [SAMPLE_W-1:0]     o_pred
);

    logic signed [PROD_W-1:0] prod [N_TERMS];
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  shifted;

    always_comb begin
        for (int i = 0; i < N_TERMS; i++) begin
            prod[i] = $signed(i_cfg.weights[WEIGHT_W*i +: WEIGHT_W])
                    * $signed({1'b0, i_terms[i]});
        end
    end

    always_comb begin
        sum = '0;
        for (int i = 0; i < N_TERMS; i++) begin
            sum = sum + SUM_W'(prod[i]);
        end
    end

    // arithmetic shift gives the floor of the quotient
    assign shifted = sum >>> i_cfg.shift;
    assign o_pred  = shifted[SAMPLE_W-1:0];

endmodule
`default_nettype wire

[hw/rtl/inter_channel_pixel_predictor_unit.sv]
// Inter-channel pixel predictor.
// Input channel: i_valid / o_stall carry one RGB pixel per beat in raster order,
// with i_frame_start marking the first pixel of an image. Output channel:
// o_valid / i_stall carry the three residuals (sample minus prediction, mod 256).
// Pixels in the first row or first column of an image give no output beat.
// Path from input beat to output beat: the row memory read and operand
// register, then the result register.
// Throughput: one pixel per cycle while the receiver does not stall; the row
// memory is read at accept, the same entry written back as the pixel moves on.
// Configuration: i_cfg_wr_en / i_cfg_index / i_cfg_data, written while idle.
// Reset clears the column counter, the row flag, the neighbour registers and
// the configuration (image width returns to 4096). The row memory is not
// cleared; the first row of an image fills it before it is read.
// When the receiver stalls, the result register holds; the operand stage
// fills behind it and then o_stall rises, so no beat is lost.
`default_nettype none
`include "inter_channel_pixel_predictor_unit_assert.svh"
module inter_channel_pixel_predictor_unit
    import icpp_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [SAMPLE_W-1:0]   i_red,
    input  wire logic [SAMPLE_W-1:0]   i_green,
    input  wire logic [SAMPLE_W-1:0]   i_blue,
    input  wire logic                  i_frame_start,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [SAMPLE_W-1:0]        o_red_residual,
    output logic [SAMPLE_W-1:0]        o_green_residual,
    output logic [SAMPLE_W-1:0]        o_blue_residual
);

    localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CMPW = (CW + 1 > IMG_WIDTH_W) ? CW + 1 : IMG_WIDTH_W;

    // configuration
    logic [RED_W_W-1:0]     r_red_w;
    logic [GREEN_W_W-1:0]   r_green_w;
    logic [BLUE_W_W-1:0]    r_blue_w;
    logic [SHIFT_W-1:0]     r_red_sh;
    logic [SHIFT_W-1:0]     r_green_sh;
    logic [SHIFT_W-1:0]     r_blue_sh;
    logic [IMG_WIDTH_W-1:0] r_image_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_w       <= '0;
            r_green_w     <= '0;
            r_blue_w      <= '0;
            r_red_sh      <= '0;
            r_green_sh    <= '0;
            r_blue_sh     <= '0;
            r_image_width <= IMAGE_WIDTH_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_RED_WEIGHTS:   r_red_w       <= i_cfg_data[RED_W_W-1:0];
                CFG_GREEN_WEIGHTS: r_green_w     <= i_cfg_data[GREEN_W_W-1:0];
                CFG_BLUE_WEIGHTS:  r_blue_w      <= i_cfg_data[BLUE_W_W-1:0];
                CFG_RED_SHIFT:     r_red_sh      <= i_cfg_data[SHIFT_W-1:0];
                CFG_GREEN_SHIFT:   r_green_sh    <= i_cfg_data[SHIFT_W-1:0];
                CFG_BLUE_SHIFT:    r_blue_sh     <= i_cfg_data[SHIFT_W-1:0];
                CFG_IMAGE_WIDTH:   r_image_width <= i_cfg_data[IMG_WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    // effective width, clamped to [2, MAX_WIDTH]
    logic [CMPW-1:0] width_eff;
    always_comb begin
        width_eff = CMPW'(r_image_width);
        if (width_eff < CMPW'(2)) begin
            width_eff = CMPW'(2);
        end else if (width_eff > CMPW'(MAX_WIDTH)) begin
            width_eff = CMPW'(MAX_WIDTH);
        end
    end

    // handshake
    logic accept;
    logic s1_adv;
    logic r_s1_valid;
    logic r_s1_produce;
    logic r_o_valid;

    assign s1_adv  = r_s1_valid && (!r_s1_produce || !r_o_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_adv;
    assign accept  = i_valid && !o_stall;

    // column tracking at accept
    logic [CW-1:0]   r_col;
    logic            r_row_nz;
    logic [CW-1:0]   col;
    logic            row_nz;
    logic [CMPW-1:0] next_col;
    logic            wrap;

    assign col      = i_frame_start ? '0 : r_col;
    assign row_nz   = i_frame_start ? 1'b0 : r_row_nz;
    assign next_col = CMPW'(col) + CMPW'(1);
    assign wrap     = next_col >= width_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row_nz <= 1'b0;
        end else if (accept) begin
            r_col    <= wrap ? '0 : next_col[CW-1:0];
            r_row_nz <= wrap ? 1'b1 : row_nz;
        end
    end

    // operand stage
    logic [CW-1:0]       r_s1_col;
    logic                r_s1_wrap;
    logic [PIXEL_W-1:0]  r_s1_cur;
    logic [PIXEL_W-1:0]  up;
    logic [PIXEL_W-1:0]  r_left;
    logic [PIXEL_W-1:0]  r_ul;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_produce <= row_nz && (col != '0);
            r_s1_col     <= col;
            r_s1_wrap    <= wrap;
            r_s1_cur     <= {i_blue, i_green, i_red};
        end
    end

    // neighbours follow the pixel leaving the operand stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_ul   <= '0;
        end else if (s1_adv) begin
            r_left <= r_s1_wrap ? '0 : r_s1_cur;
            r_ul   <= r_s1_wrap ? '0 : up;
        end
    end

    icpp_row_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_row_mem (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (col),
        .o_rd_data (up),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_col),
        .i_wr_data (r_s1_cur)
    );

    // prediction
    logic [SAMPLE_W-1:0] cur_r, cur_g, cur_b;
    logic [SAMPLE_W-1:0] ul_r, ul_g, ul_b, up_r, up_g, up_b, lf_r, lf_g, lf_b;
    t_terms              red_terms, green_terms, blue_terms;
    t_chan_cfg           red_cfg, green_cfg, blue_cfg;
    logic [SAMPLE_W-1:0] pred_r, pred_g, pred_b;

    assign {cur_b, cur_g, cur_r} = r_s1_cur;
    assign {ul_b, ul_g, ul_r}    = r_ul;
    assign {up_b, up_g, up_r}    = up;
    assign {lf_b, lf_g, lf_r}    = r_left;

    always_comb begin
        red_terms  = '0;
        red_terms[0] = ul_r;  red_terms[1] = up_r;  red_terms[2] = lf_r;
        red_terms[3] = ul_g;  red_terms[4] = up_g;  red_terms[5] = lf_g;
        red_terms[6] = cur_g;
        red_terms[7] = ul_b;  red_terms[8] = up_b;  red_terms[9] = lf_b;

        green_terms = '0;
        green_terms[0] = ul_r; green_terms[1] = up_r; green_terms[2] = lf_r;
        green_terms[3] = ul_g; green_terms[4] = up_g; green_terms[5] = lf_g;
        green_terms[6] = ul_b; green_terms[7] = up_b; green_terms[8] = lf_b;

        blue_terms[0] = ul_r;  blue_terms[1] = up_r;  blue_terms[2]  = lf_r;
        blue_terms[3] = cur_r;
        blue_terms[4] = ul_g;  blue_terms[5] = up_g;  blue_terms[6]  = lf_g;
        blue_terms[7] = cur_g;
        blue_terms[8] = ul_b;  blue_terms[9] = up_b;  blue_terms[10] = lf_b;
    end

    assign red_cfg   = '{weights: WEIGHTS_W'(r_red_w),   shift: r_red_sh};
    assign green_cfg = '{weights: WEIGHTS_W'(r_green_w), shift: r_green_sh};
    assign blue_cfg  = '{weights: WEIGHTS_W'(r_blue_w),  shift: r_blue_sh};

    icpp_chan_pred u_pred_r (.i_terms(red_terms),   .i_cfg(red_cfg),   .o_pred(pred_r));
    icpp_chan_pred u_pred_g (.i_terms(green_terms), .i_cfg(green_cfg), .o_pred(pred_g));
    icpp_chan_pred u_pred_b (.i_terms(blue_terms),  .i_cfg(blue_cfg),  .o_pred(pred_b));

    // result register
    logic [SAMPLE_W-1:0] r_res_r, r_res_g, r_res_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_adv && r_s1_produce) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_produce) begin
            r_res_r <= cur_r - pred_r;
            r_res_g <= cur_g - pred_g;
            r_res_b <= cur_b - pred_b;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_red_residual   = r_res_r;
    assign o_green_residual = r_res_g;
    assign o_blue_residual  = r_res_b;

    // a pixel with a result is never in the first column
    `ICPP_ASSERT_SAME(a_produce_col, r_s1_valid && r_s1_produce, r_s1_col != '0)
    // a frame start always lands in column zero with no result
    `ICPP_ASSERT_NEXT(a_frame_col, accept && i_frame_start, r_s1_col == '0 && !r_s1_produce)
    // a blocked operand stage keeps its pixel
    `ICPP_ASSERT_NEXT(a_s1_hold, r_s1_valid && !s1_adv,
                      r_s1_valid && $stable(r_s1_col) && $stable(r_s1_cur))

endmodule
`default_nettype wire
